// File: design/checked_frame_receiver_core_defines.svh
// Assertion helpers used by the receiver RTL.
`ifndef CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CHECKED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: design/cfr_pkg.sv
package cfr_pkg;

  // Payload buffer size and derived address width
  localparam int MAX_PAYLOAD = 32;
  localparam int PAY_AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // Field widths
  localparam int LEN_W    = 6;
  localparam int HDR_W    = 8;
  localparam int TICK_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  // Header, length and checksum bytes around the payload
  localparam int FRAME_OVERHEAD = 3;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register file
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;
  localparam logic [HDR_W-1:0]  HEADER_RESET  = 8'd0;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd200;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_TIMEOUT  = 3'd1,
    ST_HEADER   = 3'd2,
    ST_LENGTH   = 3'd3,
    ST_CHECKSUM = 3'd4
  } status_e;

  typedef struct packed {
    logic [HDR_W-1:0]  header;
    logic [TICK_W-1:0] timeout;
  } cfg_t;

  // One job per finished frame: a status item, or a payload burst of count bytes
  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [PAY_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } pay_wr_t;

endpackage

// File: design/cfr_intf.sv
// Input item channel
interface cfr_in_if import cfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LEN_W-1:0]  expected_length;
  logic [BYTE_W-1:0] rx_byte;

  modport source(output valid, output command, output expected_length, output rx_byte,
                 input ready);
  modport sink(input valid, input command, input expected_length, input rx_byte,
               output ready);
endinterface

// Result item channel
interface cfr_out_if import cfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   data_byte;
  logic                last;

  modport source(output valid, output status, output data_byte, output last, input ready);
  modport sink(input valid, input status, input data_byte, input last, output ready);
endinterface

// File: design/cfr_front.sv
module cfr_front import cfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [LEN_W-1:0]  expected_length_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              job_push_o,
  output job_t              job_o,
  input  logic              job_full_i,
  output pay_wr_t           pay_wr_o,
  input  logic              burst_done_i
);

  logic              busy_q, busy_d;
  logic [LEN_W-1:0]  frame_total_q, frame_total_d;
  logic [LEN_W-1:0]  byte_count_q, byte_count_d;
  logic [BYTE_W-1:0] xor_sum_q, xor_sum_d;
  logic              header_good_q, header_good_d;
  logic              length_good_q, length_good_d;
  logic [TICK_W-1:0] elapsed_q, elapsed_d;
  logic              burst_out_q, burst_out_d;

  logic              accept;
  logic [LEN_W-1:0]  len_clamped;
  logic [LEN_W:0]    byte_next;
  logic [TICK_W-1:0] elapsed_inc;
  logic [LEN_W-1:0]  pay_idx;

  // Hold off input while the payload buffer is being drained or the queue is full
  assign in_ready_o = !burst_out_q && !job_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Clamp the requested payload length into 1..MAX_PAYLOAD
  always_comb begin
    if (expected_length_i == '0) begin
      len_clamped = LEN_W'(1);
    end else if (expected_length_i > LEN_W'(MAX_PAYLOAD)) begin
      len_clamped = LEN_W'(MAX_PAYLOAD);
    end else begin
      len_clamped = expected_length_i;
    end
  end

  assign byte_next   = {1'b0, byte_count_q} + (LEN_W+1)'(1);
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);
  assign pay_idx     = byte_count_q - LEN_W'(2);

  // Frame tracking and classification
  always_comb begin
    busy_d        = busy_q;
    frame_total_d = frame_total_q;
    byte_count_d  = byte_count_q;
    xor_sum_d     = xor_sum_q;
    header_good_d = header_good_q;
    length_good_d = length_good_q;
    elapsed_d     = elapsed_q;
    job_push_o    = 1'b0;
    job_o.status  = ST_OK;
    job_o.count   = frame_total_q - LEN_W'(FRAME_OVERHEAD);
    pay_wr_o.we   = 1'b0;
    pay_wr_o.addr = pay_idx[PAY_AW-1:0];
    pay_wr_o.data = rx_byte_i;

    if (accept) begin
      unique case (cmd_e'(command_i))
        CMD_START: begin
          busy_d        = 1'b1;
          frame_total_d = len_clamped + LEN_W'(FRAME_OVERHEAD);
          byte_count_d  = '0;
          xor_sum_d     = '0;
          header_good_d = 1'b0;
          length_good_d = 1'b0;
          elapsed_d     = '0;
        end
        CMD_TICK: begin
          if (busy_q) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= cfg_i.timeout) begin
              busy_d       = 1'b0;
              job_push_o   = 1'b1;
              job_o.status = ST_TIMEOUT;
            end
          end
        end
        CMD_BYTE: begin
          if (busy_q) begin
            byte_count_d = byte_next[LEN_W-1:0];
            if (byte_next < {1'b0, frame_total_q}) begin
              xor_sum_d = xor_sum_q ^ rx_byte_i;
              if (byte_count_q == LEN_W'(0)) begin
                header_good_d = (rx_byte_i == cfg_i.header);
              end else if (byte_count_q == LEN_W'(1)) begin
                length_good_d = (rx_byte_i == BYTE_W'(frame_total_q - LEN_W'(2)));
              end else begin
                pay_wr_o.we = 1'b1;
              end
            end else begin
              // checksum byte closes the frame
              busy_d     = 1'b0;
              job_push_o = 1'b1;
              if (!header_good_q) begin
                job_o.status = ST_HEADER;
              end else if (!length_good_q) begin
                job_o.status = ST_LENGTH;
              end else if (xor_sum_q != rx_byte_i) begin
                job_o.status = ST_CHECKSUM;
              end else begin
                job_o.status = ST_OK;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Buffer is owned by the back end from an ok job until its last byte is read
  always_comb begin
    burst_out_d = burst_out_q;
    if (burst_done_i) begin
      burst_out_d = 1'b0;
    end
    if (job_push_o && (job_o.status == ST_OK)) begin
      burst_out_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      frame_total_q <= '0;
      byte_count_q  <= '0;
      xor_sum_q     <= '0;
      header_good_q <= 1'b0;
      length_good_q <= 1'b0;
      elapsed_q     <= '0;
      burst_out_q   <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      frame_total_q <= frame_total_d;
      byte_count_q  <= byte_count_d;
      xor_sum_q     <= xor_sum_d;
      header_good_q <= header_good_d;
      length_good_q <= length_good_d;
      elapsed_q     <= elapsed_d;
      burst_out_q   <= burst_out_d;
    end
  end

endmodule

// File: design/cfr_queue.sv
module cfr_queue import cfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/cfr_back.sv
`include "checked_frame_receiver_core_defines.svh"

module cfr_back import cfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  input  job_t                job_i,
  output logic                job_pop_o,
  input  pay_wr_t             pay_wr_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   data_byte_o,
  output logic                last_o,
  output logic                burst_done_o
);

  typedef enum logic [1:0] {
    BK_IDLE  = 2'b01,
    BK_BURST = 2'b10
  } bk_state_e;

  bk_state_e         state_q, state_d;
  logic [BYTE_W-1:0] pay_mem_q [MAX_PAYLOAD];
  logic [PAY_AW-1:0] rd_idx_q, rd_idx_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic              last_q, last_d;
  logic [BYTE_W-1:0] data_q;
  logic [PAY_AW-1:0] rd_addr;
  logic              load_ok, load_err, out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Emission sequencer: one status item, or the payload read out byte by byte
  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    left_d       = left_q;
    status_d     = status_q;
    last_d       = last_q;
    rd_addr      = rd_idx_q;
    load_ok      = 1'b0;
    load_err     = 1'b0;
    job_pop_o    = 1'b0;
    burst_done_o = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i && out_free) begin
          job_pop_o = 1'b1;
          if (job_i.status == ST_OK) begin
            load_ok  = 1'b1;
            rd_addr  = '0;
            status_d = ST_OK;
            last_d   = (job_i.count == LEN_W'(1));
            left_d   = job_i.count - LEN_W'(1);
            rd_idx_d = PAY_AW'(1);
            if (job_i.count == LEN_W'(1)) begin
              burst_done_o = 1'b1;
            end else begin
              state_d = BK_BURST;
            end
          end else begin
            load_err = 1'b1;
            status_d = job_i.status;
            last_d   = 1'b1;
          end
        end
      end
      BK_BURST: begin
        if (out_free) begin
          load_ok  = 1'b1;
          last_d   = (left_q == LEN_W'(1));
          left_d   = left_q - LEN_W'(1);
          rd_idx_d = rd_idx_q + PAY_AW'(1);
          if (left_q == LEN_W'(1)) begin
            burst_done_o = 1'b1;
            state_d      = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign out_valid_d = (load_ok || load_err) ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Payload buffer, written by the front end
  always_ff @(posedge clk_i) begin
    if (pay_wr_i.we) begin
      pay_mem_q[pay_wr_i.addr] <= pay_wr_i.data;
    end
  end

  // Output register doubles as the buffer's read register
  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      data_q <= pay_mem_q[rd_addr];
    end else if (load_err) begin
      data_q <= '0;
    end
    status_q <= status_d;
    last_q   <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rd_idx_q    <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;

  // Checks
  `CFR_ASSERT(a_burst_holds_item, (state_q == BK_BURST) |-> out_valid_q, "burst without item")
  `CFR_ASSERT(a_burst_has_bytes, (state_q == BK_BURST) |-> (left_q != '0), "empty burst")
  `CFR_ASSERT(a_done_shows_last, burst_done_o |=> (out_valid_q && last_q), "done w/o last")
  `CFR_ASSERT(a_pop_when_idle, job_pop_o |-> (state_q == BK_IDLE), "pop during burst")

endmodule

// File: design/checked_frame_receiver_core.sv
// Frame receiver with XOR checksum. A start item arms reception for a payload of
// 1..32 bytes; byte items then bring header, length, payload and checksum, and tick
// items count time toward the timeout register. Each finished or timed-out frame
// gives either its payload bytes (status 0, last on the final byte) or a single
// status item. Input items are taken one per cycle while a frame arrives and the job
// queue is not full. Once a good frame completes, its payload is read out of the
// internal buffer one byte per cycle (output backpressure permitting), and input is
// held off from the cycle after the checksum byte until the last payload byte has
// been read; that hold grows while earlier status items drain or the output stalls.
// Status results go through a two-entry job queue; input also stalls while that
// queue is full. Registers: expected header at 0x0, timeout in ticks at 0x4.
module checked_frame_receiver_core import cfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cfr_in_if.sink            in_chan,
  cfr_out_if.source         out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [HDR_W-1:0]  header_q;
  logic [TICK_W-1:0] timeout_q;
  cfg_t              cfg;
  logic              cfg_we;

  logic    job_push, job_full, job_pop, job_empty;
  job_t    job_in, job_head;
  pay_wr_t pay_wr;
  logic    burst_done;

  // Register file
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HEADER_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_HEADER:  header_q  <= pwdata[HDR_W-1:0];
        REG_TIMEOUT: timeout_q <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HEADER:  prdata = APB_DW'(header_q);
      REG_TIMEOUT: prdata = APB_DW'(timeout_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg.header  = header_q;
  assign cfg.timeout = timeout_q;

  cfr_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (in_chan.valid),
    .in_ready_o        (in_chan.ready),
    .command_i         (in_chan.command),
    .expected_length_i (in_chan.expected_length),
    .rx_byte_i         (in_chan.rx_byte),
    .job_push_o        (job_push),
    .job_o             (job_in),
    .job_full_i        (job_full),
    .pay_wr_o          (pay_wr),
    .burst_done_i      (burst_done)
  );

  cfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .job_o   (job_head)
  );

  cfr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!job_empty),
    .job_i        (job_head),
    .job_pop_o    (job_pop),
    .pay_wr_i     (pay_wr),
    .out_valid_o  (out_chan.valid),
    .out_ready_i  (out_chan.ready),
    .status_o     (out_chan.status),
    .data_byte_o  (out_chan.data_byte),
    .last_o       (out_chan.last),
    .burst_done_o (burst_done)
  );

endmodule
